/* rtl/mcpe_pkg.sv */
// ----------------------------------------------------------------------------
// Morse code pattern encoder package
// Shared widths, register indexes, microcode format and the glyph table.
// ----------------------------------------------------------------------------
`default_nettype none

package mcpe_pkg;

    localparam int UNIT_IDX_W = 10;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_PUNCT_EN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EOM_EN   = 1'd1;

    typedef logic [3:0] t_upc;

    localparam t_upc U_IDLE  = 4'd0;
    localparam t_upc U_ELEM  = 4'd1;
    localparam t_upc U_TYPE  = 4'd2;
    localparam t_upc U_DOT   = 4'd3;
    localparam t_upc U_DASH  = 4'd4;
    localparam t_upc U_DASH2 = 4'd5;
    localparam t_upc U_OFF   = 4'd6;
    localparam t_upc U_TR1   = 4'd7;
    localparam t_upc U_TR2   = 4'd8;
    localparam t_upc U_TR3   = 4'd9;
    localparam t_upc U_END   = 4'd10;
    localparam t_upc U_ELD   = 4'd11;
    localparam t_upc U_EOFF  = 4'd12;
    localparam t_upc U_EFIN  = 4'd13;
    localparam t_upc U_SLD   = 4'd14;
    localparam t_upc U_SOFF  = 4'd15;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_FULL,
        COND_NO_ELEM,
        COND_DASH,
        COND_CNT_Z,
        COND_CNTZ_FULL,
        COND_EOT
    } t_cond;

    typedef struct packed {
        logic       take;
        logic       emit;
        logic       mark;
        t_cond      cond;
        logic [1:0] gap;
        t_upc       jaddr;
        t_upc       naddr;
        logic       ld_cnt;
        logic [2:0] cnt_val;
        logic       dec_cnt;
        logic       shift;
        logic       fin;
        logic       clr_units;
    } t_uword;

    typedef struct packed {
        logic       take;
        logic       emit;
        logic       mark;
        logic       ld_cnt;
        logic [2:0] cnt_val;
        logic       dec_cnt;
        logic       shift;
        logic       fin;
        logic       clr_units;
    } t_ctl;

    typedef struct packed {
        logic       accept;
        t_upc       entry;
        logic       no_elem;
        logic       dash;
        logic       cnt_zero;
        logic [3:0] full;
        logic       eot;
        logic       stall;
        logic       hold_valid;
    } t_stat;

    typedef struct packed {
        logic       hit;
        logic       punct;
        logic [2:0] len;
        logic [5:0] bits;
    } t_glyph;

    // Elements are left aligned, first element in the top bit; 1 is a dash.
    localparam t_glyph GLYPH_EOM = '{hit: 1'b1, punct: 1'b0, len: 3'd5, bits: 6'b010100};

    function automatic t_glyph mk(input logic punct, input logic [2:0] len,
                                  input logic [5:0] bits);
        t_glyph g;
        g.hit   = 1'b1;
        g.punct = punct;
        g.len   = len;
        g.bits  = bits;
        return g;
    endfunction

    function automatic t_glyph glyph_lookup(input logic [7:0] ch);
        t_glyph g;
        g = '0;
        case (ch)
            "A": g = mk(1'b0, 3'd2, 6'b010000);
            "B": g = mk(1'b0, 3'd4, 6'b100000);
            "C": g = mk(1'b0, 3'd4, 6'b101000);
            "D": g = mk(1'b0, 3'd3, 6'b100000);
            "E": g = mk(1'b0, 3'd1, 6'b000000);
            "F": g = mk(1'b0, 3'd4, 6'b001000);
            "G": g = mk(1'b0, 3'd3, 6'b110000);
            "H": g = mk(1'b0, 3'd4, 6'b000000);
            "I": g = mk(1'b0, 3'd2, 6'b000000);
            "J": g = mk(1'b0, 3'd4, 6'b011100);
            "K": g = mk(1'b0, 3'd3, 6'b101000);
            "L": g = mk(1'b0, 3'd4, 6'b010000);
            "M": g = mk(1'b0, 3'd2, 6'b110000);
            "N": g = mk(1'b0, 3'd2, 6'b100000);
            "O": g = mk(1'b0, 3'd3, 6'b111000);
            "P": g = mk(1'b0, 3'd4, 6'b011000);
            "Q": g = mk(1'b0, 3'd4, 6'b110100);
            "R": g = mk(1'b0, 3'd3, 6'b010000);
            "S": g = mk(1'b0, 3'd3, 6'b000000);
            "T": g = mk(1'b0, 3'd1, 6'b100000);
            "U": g = mk(1'b0, 3'd3, 6'b001000);
            "V": g = mk(1'b0, 3'd4, 6'b000100);
            "W": g = mk(1'b0, 3'd3, 6'b011000);
            "X": g = mk(1'b0, 3'd4, 6'b100100);
            "Y": g = mk(1'b0, 3'd4, 6'b101100);
            "Z": g = mk(1'b0, 3'd4, 6'b110000);
            "0": g = mk(1'b0, 3'd5, 6'b111110);
            "1": g = mk(1'b0, 3'd5, 6'b011110);
            "2": g = mk(1'b0, 3'd5, 6'b001110);
            "3": g = mk(1'b0, 3'd5, 6'b000110);
            "4": g = mk(1'b0, 3'd5, 6'b000010);
            "5": g = mk(1'b0, 3'd5, 6'b000000);
            "6": g = mk(1'b0, 3'd5, 6'b100000);
            "7": g = mk(1'b0, 3'd5, 6'b110000);
            "8": g = mk(1'b0, 3'd5, 6'b111000);
            "9": g = mk(1'b0, 3'd5, 6'b111100);
            ".": g = mk(1'b1, 3'd6, 6'b010101);
            ",": g = mk(1'b1, 3'd6, 6'b110011);
            "?": g = mk(1'b1, 3'd6, 6'b001100);
            ":": g = mk(1'b1, 3'd6, 6'b111000);
            "-": g = mk(1'b1, 3'd6, 6'b100001);
            "!": g = mk(1'b1, 3'd6, 6'b101011);
            "&": g = mk(1'b1, 3'd5, 6'b010000);
            "@": g = mk(1'b1, 3'd6, 6'b011010);
            ")": g = mk(1'b1, 3'd6, 6'b101101);
            "(": g = mk(1'b1, 3'd5, 6'b101100);
            "/": g = mk(1'b1, 3'd5, 6'b100100);
            "'": g = mk(1'b1, 3'd6, 6'b011110);
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

/* rtl/mcpe_if.sv */
// ----------------------------------------------------------------------------
// Morse code pattern encoder channels
// Request, unit and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcpe_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] char_code;

    modport source (output valid, output opcode, output char_code, input ready);
    modport sink (input valid, input opcode, input char_code, output ready);
endinterface

interface mcpe_out_if;
    logic                            valid;
    logic                            ready;
    logic                            mark;
    logic [mcpe_pkg::UNIT_IDX_W-1:0] unit_index;
    logic                            last;

    modport source (output valid, output mark, output unit_index, output last,
                    input ready);
    modport sink (input valid, input mark, input unit_index, input last,
                  output ready);
endinterface

interface mcpe_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mcpe_pkg::CFG_IDX_W-1:0] index;
    logic                           data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/mcpe_urom.sv */
// ----------------------------------------------------------------------------
// Morse code pattern encoder microcode ROM
// One control word per program step of the unit sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpe_urom (
    input  mcpe_pkg::t_upc   i_pc,
    output mcpe_pkg::t_uword o_word
);
    import mcpe_pkg::*;

    function automatic t_uword uw(
        input logic       take,
        input logic       emit,
        input logic       mark,
        input t_cond      cond,
        input logic [1:0] gap,
        input t_upc       jaddr,
        input t_upc       naddr,
        input logic       ld_cnt,
        input logic [2:0] cnt_val,
        input logic       dec_cnt,
        input logic       shift,
        input logic       fin,
        input logic       clr_units
    );
        t_uword w;
        w.take      = take;
        w.emit      = emit;
        w.mark      = mark;
        w.cond      = cond;
        w.gap       = gap;
        w.jaddr     = jaddr;
        w.naddr     = naddr;
        w.ld_cnt    = ld_cnt;
        w.cnt_val   = cnt_val;
        w.dec_cnt   = dec_cnt;
        w.shift     = shift;
        w.fin       = fin;
        w.clr_units = clr_units;
        return w;
    endfunction

    always_comb begin
        unique case (i_pc)
            U_IDLE:  o_word = uw(1'b1, 1'b0, 1'b0, COND_NONE, 2'd0, U_IDLE, U_IDLE,
                                 1'b0, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0);
            U_ELEM:  o_word = uw(1'b0, 1'b0, 1'b0, COND_NO_ELEM, 2'd0, U_TR1, U_TYPE,
                                 1'b0, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0);
            U_TYPE:  o_word = uw(1'b0, 1'b0, 1'b0, COND_DASH, 2'd0, U_DASH, U_DOT,
                                 1'b0, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0);
            U_DOT:   o_word = uw(1'b0, 1'b1, 1'b1, COND_FULL, 2'd1, U_END, U_OFF,
                                 1'b0, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0);
            U_DASH:  o_word = uw(1'b0, 1'b1, 1'b1, COND_FULL, 2'd3, U_END, U_DASH2,
                                 1'b1, 3'd2, 1'b0, 1'b0, 1'b0, 1'b0);
            U_DASH2: o_word = uw(1'b0, 1'b1, 1'b1, COND_CNT_Z, 2'd0, U_OFF, U_DASH2,
                                 1'b0, 3'd0, 1'b1, 1'b0, 1'b0, 1'b0);
            U_OFF:   o_word = uw(1'b0, 1'b1, 1'b0, COND_FULL, 2'd0, U_END, U_ELEM,
                                 1'b0, 3'd0, 1'b0, 1'b1, 1'b0, 1'b0);
            U_TR1:   o_word = uw(1'b0, 1'b1, 1'b0, COND_FULL, 2'd2, U_END, U_TR2,
                                 1'b0, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0);
            U_TR2:   o_word = uw(1'b0, 1'b1, 1'b0, COND_FULL, 2'd1, U_END, U_TR3,
                                 1'b0, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0);
            U_TR3:   o_word = uw(1'b0, 1'b1, 1'b0, COND_FULL, 2'd0, U_END, U_END,
                                 1'b0, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0);
            U_END:   o_word = uw(1'b0, 1'b0, 1'b0, COND_EOT, 2'd0, U_ELD, U_IDLE,
                                 1'b0, 3'd0, 1'b0, 1'b0, 1'b1, 1'b0);
            U_ELD:   o_word = uw(1'b0, 1'b0, 1'b0, COND_NONE, 2'd0, U_EOFF, U_EOFF,
                                 1'b1, 3'd7, 1'b0, 1'b0, 1'b0, 1'b0);
            U_EOFF:  o_word = uw(1'b0, 1'b1, 1'b0, COND_CNTZ_FULL, 2'd0, U_EFIN, U_EOFF,
                                 1'b0, 3'd0, 1'b1, 1'b0, 1'b0, 1'b0);
            U_EFIN:  o_word = uw(1'b0, 1'b0, 1'b0, COND_NONE, 2'd0, U_IDLE, U_IDLE,
                                 1'b0, 3'd0, 1'b0, 1'b0, 1'b1, 1'b1);
            U_SLD:   o_word = uw(1'b0, 1'b0, 1'b0, COND_NONE, 2'd0, U_SOFF, U_SOFF,
                                 1'b1, 3'd4, 1'b0, 1'b0, 1'b0, 1'b0);
            U_SOFF:  o_word = uw(1'b0, 1'b1, 1'b0, COND_CNTZ_FULL, 2'd0, U_END, U_SOFF,
                                 1'b0, 3'd0, 1'b1, 1'b0, 1'b0, 1'b0);
            default: o_word = uw(1'b1, 1'b0, 1'b0, COND_NONE, 2'd0, U_IDLE, U_IDLE,
                                 1'b0, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        endcase
    end

endmodule

`default_nettype wire

/* rtl/mcpe_sequencer.sv */
// ----------------------------------------------------------------------------
// Morse code pattern encoder sequencer
// Step counter with conditional jumps; turns control words into datapath controls.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpe_sequencer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mcpe_pkg::t_stat i_stat,
    output mcpe_pkg::t_ctl  o_ctl
);
    import mcpe_pkg::*;

    t_upc   r_pc;
    t_upc   n_pc;
    t_uword word;
    logic   jump;
    logic   go;

    mcpe_urom u_urom (
        .i_pc   (r_pc),
        .o_word (word)
    );

    always_comb begin
        unique case (word.cond)
            COND_NONE:      jump = 1'b0;
            COND_FULL:      jump = i_stat.full[word.gap];
            COND_NO_ELEM:   jump = i_stat.no_elem;
            COND_DASH:      jump = i_stat.dash;
            COND_CNT_Z:     jump = i_stat.cnt_zero;
            COND_CNTZ_FULL: jump = i_stat.cnt_zero || i_stat.full[0];
            COND_EOT:       jump = i_stat.eot;
            default:        jump = 1'b0;
        endcase
    end

    assign go = !jump;

    always_comb begin
        o_ctl.take      = word.take;
        o_ctl.emit      = word.emit && go;
        o_ctl.mark      = word.mark;
        o_ctl.ld_cnt    = word.ld_cnt && go;
        o_ctl.cnt_val   = word.cnt_val;
        o_ctl.dec_cnt   = word.dec_cnt && go;
        o_ctl.shift     = word.shift && go;
        o_ctl.fin       = word.fin && go;
        o_ctl.clr_units = word.clr_units && go;
    end

    always_comb begin
        if (i_stat.stall) begin
            n_pc = r_pc;
        end else if (i_stat.accept) begin
            n_pc = i_stat.entry;
        end else if (jump) begin
            n_pc = word.jaddr;
        end else begin
            n_pc = word.naddr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= U_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

/* rtl/mcpe_datapath.sv */
// ----------------------------------------------------------------------------
// Morse code pattern encoder datapath
// Character decode, element shifter, unit counter, hold stage and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpe_datapath #(
    parameter int PATTERN_CAPACITY = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mcpe_in_if.sink         i_item,
    mcpe_cfg_if.sink        i_cfg,
    mcpe_out_if.source      o_unit,
    input  mcpe_pkg::t_ctl  i_ctl,
    output mcpe_pkg::t_stat o_stat
);
    import mcpe_pkg::*;

    localparam int CNT_W = $clog2(PATTERN_CAPACITY + 1);

    logic                  r_punct_en;
    logic                  r_eom_en;
    logic [CNT_W-1:0]      r_units;
    logic [5:0]            r_elem;
    logic [2:0]            r_len;
    logic [2:0]            r_cnt;
    logic                  r_eot;
    logic                  r_hold_valid;
    logic                  r_hold_mark;
    logic [UNIT_IDX_W-1:0] r_hold_idx;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic                  r_out_mark;
    logic [UNIT_IDX_W-1:0] r_out_idx;
    logic                  r_out_last;

    logic [CNT_W:0]            units_x;
    logic [CNT_W+UNIT_IDX_W-1:0] units_ext;
    logic [7:0]            uc;
    t_glyph                glyph;
    t_glyph                load_glyph;
    logic [3:0]            full;
    t_upc                  entry;
    logic                  skip;
    logic                  accept;
    logic                  push;
    logic                  stall;
    logic                  act;

    assign units_x   = {1'b0, r_units};
    assign units_ext = (CNT_W + UNIT_IDX_W)'(r_units);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            full[k] = (units_x + (CNT_W + 1)'(k)) >= (CNT_W + 1)'(PATTERN_CAPACITY);
        end
    end

    assign skip = (units_x + (CNT_W + 1)'(10)) >= (CNT_W + 1)'(PATTERN_CAPACITY);
    assign uc   = (i_item.char_code >= "a" && i_item.char_code <= "z") ?
                  (i_item.char_code - 8'd32) : i_item.char_code;
    assign glyph = glyph_lookup(uc);

    always_comb begin
        load_glyph = glyph;
        if (i_item.opcode) begin
            load_glyph = GLYPH_EOM;
            entry = r_eom_en ? U_ELEM : U_ELD;
        end else if (skip) begin
            entry = U_END;
        end else if (uc == " ") begin
            entry = U_SLD;
        end else if (glyph.hit && (!glyph.punct || r_punct_en)) begin
            entry = U_ELEM;
        end else begin
            entry = U_END;
        end
    end

    assign i_item.ready = i_ctl.take;
    assign accept       = i_item.valid && i_ctl.take;
    assign i_cfg.ready  = 1'b1;

    assign stall = (i_ctl.emit || i_ctl.fin) && r_hold_valid && r_out_valid && !o_unit.ready;
    assign push  = (i_ctl.emit || i_ctl.fin) && r_hold_valid && !stall;
    assign act   = !stall;

    always_comb begin
        if (push) begin
            n_out_valid = 1'b1;
        end else if (o_unit.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_stat.accept     = accept;
    assign o_stat.entry      = entry;
    assign o_stat.full       = full;
    assign o_stat.no_elem    = (r_len == 3'd0);
    assign o_stat.dash       = r_elem[5];
    assign o_stat.cnt_zero   = (r_cnt == 3'd0);
    assign o_stat.eot        = r_eot;
    assign o_stat.stall      = stall;
    assign o_stat.hold_valid = r_hold_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_punct_en   <= 1'b1;
            r_eom_en     <= 1'b1;
            r_units      <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_PUNCT_EN: r_punct_en <= i_cfg.data;
                    CFG_EOM_EN:   r_eom_en   <= i_cfg.data;
                    default:      r_punct_en <= r_punct_en;
                endcase
            end
            r_out_valid <= n_out_valid;
            if (act && i_ctl.emit) begin
                r_units      <= r_units + CNT_W'(1);
                r_hold_valid <= 1'b1;
            end
            if (act && i_ctl.fin) begin
                r_hold_valid <= 1'b0;
                if (i_ctl.clr_units) begin
                    r_units <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_elem <= load_glyph.bits;
            r_len  <= load_glyph.len;
            r_eot  <= i_item.opcode;
        end else if (act && i_ctl.shift) begin
            r_elem <= {r_elem[4:0], 1'b0};
            r_len  <= r_len - 3'd1;
        end
        if (act && i_ctl.ld_cnt) begin
            r_cnt <= i_ctl.cnt_val;
        end else if (act && i_ctl.dec_cnt) begin
            r_cnt <= r_cnt - 3'd1;
        end
        if (act && i_ctl.emit) begin
            r_hold_mark <= i_ctl.mark;
            r_hold_idx  <= units_ext[UNIT_IDX_W-1:0];
        end
        if (push) begin
            r_out_mark <= r_hold_mark;
            r_out_idx  <= r_hold_idx;
            r_out_last <= i_ctl.fin;
        end
    end

    assign o_unit.valid      = r_out_valid;
    assign o_unit.mark       = r_out_mark;
    assign o_unit.unit_index = r_out_idx;
    assign o_unit.last       = r_out_last;

endmodule

`default_nettype wire

/* rtl/morse_code_pattern_encoder.sv */
// ----------------------------------------------------------------------------
// Morse code pattern encoder
// Turns message characters into the on/off unit pattern of Morse code.
//
//   Channel   Dir  Payload                      Moves
//   i_item    in   opcode, char_code            one request per character
//   o_unit    out  mark, unit_index, last       one pattern unit per transfer
//   i_cfg     in   index, data                  one register write
//
// The time a request takes is set by the microcode steps it runs: the on and off
// steps for each dot and dash, plus the gap and end-of-text steps.
// Each unit is held until the next emit or finish step so that the final one carries
// last; a unit waiting on o_unit stalls the sequencer, not the request side.
// Reset is synchronous and restores both enables to 1 and the unit count to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_code_pattern_encoder #(
    parameter int PATTERN_CAPACITY = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mcpe_in_if.sink    i_item,
    mcpe_cfg_if.sink   i_cfg,
    mcpe_out_if.source o_unit
);
    import mcpe_pkg::*;

    t_ctl  ctl;
    t_stat stat;

    mcpe_sequencer u_sequencer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    mcpe_datapath #(
        .PATTERN_CAPACITY (PATTERN_CAPACITY)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cfg   (i_cfg),
        .o_unit  (o_unit),
        .i_ctl   (ctl),
        .o_stat  (stat)
    );

    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.ready |-> !stat.hold_valid)
        else $error("held unit left over while waiting for a request");

    a_no_emit_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.emit && !stat.stall) |-> !stat.full[0])
        else $error("unit emitted beyond pattern capacity");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("sequencer did not leave idle after a request");

    a_fin_single_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctl.emit && ctl.fin))
        else $error("emit and finish in the same step");

endmodule

`default_nettype wire

/* tb/sv/mcpe_tb_pkg.sv */
// ----------------------------------------------------------------------------
// Morse code pattern encoder test package
// Request opcodes shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package mcpe_tb_pkg;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_EOT  = 1'b1;

endpackage

/* tb/sv/mcpe_pattern_checker.sv */
// ----------------------------------------------------------------------------
// Morse code pattern checker
// Watches the request, unit and configuration channels, builds the expected
// on/off unit sequence for every accepted request and compares each unit
// that leaves the encoder with the oldest expected one.
// ----------------------------------------------------------------------------
module mcpe_pattern_checker #(
    parameter int CAPACITY = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mcpe_in_if   i_item,
    mcpe_cfg_if  i_cfg,
    mcpe_out_if  i_unit,
    output int   o_errors,
    output int   o_pending,
    output int   o_items_with_units
);
    timeunit 1ns;
    timeprecision 1ps;

    import mcpe_pkg::*;
    import mcpe_tb_pkg::*;

    localparam int MAX_BURST   = 24;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic                  mark;
        logic [UNIT_IDX_W-1:0] idx;
        logic                  last;
    } t_unit;

    t_unit expected_units[$];
    t_unit burst[$];
    int    msg_units;
    logic  punct_on;
    logic  eom_on;

    initial begin
        o_errors           = 0;
        o_pending          = 0;
        o_items_with_units = 0;
    end

    function automatic string morse_of(input logic [7:0] c, input logic marks_on);
        string s;
        s = "";
        case (c)
            "A": s = ".-";      "B": s = "-...";    "C": s = "-.-.";
            "D": s = "-..";     "E": s = ".";       "F": s = "..-.";
            "G": s = "--.";     "H": s = "....";    "I": s = "..";
            "J": s = ".---";    "K": s = "-.-";     "L": s = ".-..";
            "M": s = "--";      "N": s = "-.";      "O": s = "---";
            "P": s = ".--.";    "Q": s = "--.-";    "R": s = ".-.";
            "S": s = "...";     "T": s = "-";       "U": s = "..-";
            "V": s = "...-";    "W": s = ".--";     "X": s = "-..-";
            "Y": s = "-.--";    "Z": s = "--..";
            "0": s = "-----";   "1": s = ".----";   "2": s = "..---";
            "3": s = "...--";   "4": s = "....-";   "5": s = ".....";
            "6": s = "-....";   "7": s = "--...";   "8": s = "---..";
            "9": s = "----.";
            default: s = "";
        endcase
        if (s.len() == 0 && marks_on) begin
            case (c)
                ".": s = ".-.-.-";  ",": s = "--..--";  "?": s = "..--..";
                ":": s = "---...";  "-": s = "-....-";  "!": s = "-.-.--";
                "&": s = ".-...";   "@": s = ".--.-.";  ")": s = "-.--.-";
                "(": s = "-.--.";   "/": s = "-..-.";   "'": s = ".----.";
                default: s = "";
            endcase
        end
        return s;
    endfunction

    // Units past the burst limit still advance the position in the message.
    function void add_unit(input logic on);
        t_unit u;
        if (burst.size() < MAX_BURST) begin
            u.mark = on;
            u.idx  = UNIT_IDX_W'(msg_units);
            u.last = 1'b0;
            burst.push_back(u);
        end
        msg_units++;
    endfunction

    function void play_code(input string code);
        int k;
        for (k = 0; k < code.len(); k++) begin
            if (code[k] == ".") begin
                if (msg_units + 1 >= CAPACITY) return;
                add_unit(1'b1);
            end else begin
                if (msg_units + 3 >= CAPACITY) return;
                repeat (3) add_unit(1'b1);
            end
            if (msg_units >= CAPACITY) return;
            add_unit(1'b0);
        end
        if (msg_units + 2 >= CAPACITY) return;
        add_unit(1'b0);
        if (msg_units + 1 >= CAPACITY) return;
        add_unit(1'b0);
        if (msg_units >= CAPACITY) return;
        add_unit(1'b0);
    endfunction

    function void encode_item(input logic op, input logic [7:0] ch);
        logic [7:0] c;
        string      code;
        int         n;
        burst.delete();
        if (op == OP_EOT) begin
            if (eom_on) play_code(".-.-.");
            for (n = 0; n < 7 && msg_units < CAPACITY; n++) add_unit(1'b0);
            msg_units = 0;
        end else if (msg_units + 10 < CAPACITY) begin
            c = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
            if (c == " ") begin
                for (n = 0; n < 4 && msg_units < CAPACITY; n++) add_unit(1'b0);
            end else begin
                code = morse_of(c, punct_on);
                if (code.len() > 0) play_code(code);
            end
        end
        if (burst.size() > 0) begin
            burst[burst.size() - 1].last = 1'b1;
            o_items_with_units++;
        end
        foreach (burst[k]) expected_units.push_back(burst[k]);
    endfunction

    function void check_unit();
        t_unit want;
        if (expected_units.size() == 0) begin
            if (o_errors < MAX_REPORTS) begin
                $display("unexpected unit: mark=%0d index=%0d last=%0d",
                         i_unit.mark, i_unit.unit_index, i_unit.last);
            end
            o_errors++;
            return;
        end
        want = expected_units.pop_front();
        if (want.mark !== i_unit.mark || want.idx !== i_unit.unit_index ||
            want.last !== i_unit.last) begin
            if (o_errors < MAX_REPORTS) begin
                $display({"unit mismatch: expected mark=%0d index=%0d last=%0d,",
                          " got mark=%0d index=%0d last=%0d"},
                         want.mark, want.idx, want.last,
                         i_unit.mark, i_unit.unit_index, i_unit.last);
            end
            o_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            msg_units = 0;
            punct_on  = 1'b1;
            eom_on    = 1'b1;
            expected_units.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_PUNCT_EN) begin
                    punct_on = i_cfg.data;
                end else if (i_cfg.index == CFG_EOM_EN) begin
                    eom_on = i_cfg.data;
                end
            end
            if (i_item.valid && i_item.ready) encode_item(i_item.opcode, i_item.char_code);
            if (i_unit.valid && i_unit.ready) check_unit();
        end
        o_pending = expected_units.size();
    end

endmodule

/* tb/sv/morse_code_pattern_encoder_tb.sv */
// ----------------------------------------------------------------------------
// Morse code pattern encoder testbench
// Drives directed characters, then random messages with long runs that reach
// the pattern capacity, under changing enables and handshake idling, and
// reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module morse_code_pattern_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mcpe_pkg::*;
    import mcpe_tb_pkg::*;

    localparam int CAPACITY      = 1024;
    localparam int SETTLE_CYCLES = 50;
    localparam int HOLD_CYCLES   = 400;
    localparam int SEGMENTS      = 6;
    localparam int SEGMENT_ITEMS = 55;

    logic i_clk;
    logic i_rst_n;
    logic hold_off   = 1'b0;
    logic squeeze_go = 1'b0;
    int   tx_idle_pct = 31;
    int   rx_idle_pct = 69;
    int   errors;
    int   pending;
    int   items_with_units;

    mcpe_in_if  item_ch ();
    mcpe_cfg_if cfg_ch ();
    mcpe_out_if unit_ch ();

    morse_code_pattern_encoder #(
        .PATTERN_CAPACITY(CAPACITY)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (item_ch),
        .i_cfg  (cfg_ch),
        .o_unit (unit_ch)
    );

    mcpe_pattern_checker #(
        .CAPACITY(CAPACITY)
    ) checker_i (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_item            (item_ch),
        .i_cfg             (cfg_ch),
        .i_unit            (unit_ch),
        .o_errors          (errors),
        .o_pending         (pending),
        .o_items_with_units(items_with_units)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(64'd10_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        unit_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            unit_ch.ready <= !hold_off && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        int n;
        wait (squeeze_go);
        @(posedge i_clk);
        hold_off <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Returns with valid still high so back-to-back requests keep it asserted.
    task automatic send_item(input logic op, input logic [7:0] ch);
        if ($urandom_range(99) < tx_idle_pct) begin
            item_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        item_ch.valid     <= 1'b1;
        item_ch.opcode    <= op;
        item_ch.char_code <= ch;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    task automatic configure(input logic punct, input logic eom);
        write_reg(CFG_PUNCT_EN, punct);
        write_reg(CFG_EOM_EN, eom);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_char(input int heavy_pct);
        string heavy_set;
        string mark_set;
        int    r;
        heavy_set = "0189,!)'@JQY";
        mark_set  = ".,?:-!&@)(/'";
        if ($urandom_range(99) < heavy_pct) begin
            return heavy_set[$urandom_range(heavy_set.len() - 1)];
        end
        r = $urandom_range(99);
        if (r < 40) return 8'("A" + $urandom_range(25));
        if (r < 55) return 8'("a" + $urandom_range(25));
        if (r < 67) return 8'("0" + $urandom_range(9));
        if (r < 77) return " ";
        if (r < 92) return mark_set[$urandom_range(mark_set.len() - 1)];
        return 8'($urandom_range(255));
    endfunction

    // Long messages are dense in long codes so that they run into the capacity.
    task automatic send_message(input logic is_long);
        int n;
        int k;
        int heavy;
        n     = is_long ? $urandom_range(48, 64) : $urandom_range(1, 14);
        heavy = is_long ? 75 : 10;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(99) < 6) begin
                send_item(is_long ? OP_CHAR : 1'($urandom_range(1)), 8'($urandom_range(255)));
            end else begin
                send_item(OP_CHAR, pick_char(heavy));
            end
        end
        if ($urandom_range(99) < 90) send_item(OP_EOT, 8'($urandom_range(255)));
    endtask

    initial begin
        string marks;
        int    k;
        int    seg;
        int    goal;
        item_ch.valid     <= 1'b0;
        item_ch.opcode    <= OP_CHAR;
        item_ch.char_code <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= CFG_PUNCT_EN;
        cfg_ch.data       <= 1'b0;
        i_rst_n           <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        configure(1'b1, 1'b1);
        marks = ".,?:-!&@)(/'";
        send_item(OP_CHAR, "A");
        send_item(OP_CHAR, "z");
        send_item(OP_CHAR, "0");
        send_item(OP_CHAR, "9");
        send_item(OP_CHAR, " ");
        for (k = 0; k < marks.len(); k++) send_item(OP_CHAR, marks[k]);
        send_item(OP_CHAR, 8'h00);
        send_item(OP_CHAR, 8'hFF);
        send_item(OP_CHAR, "#");
        send_item(OP_EOT, 8'h00);
        drain();
        configure(1'b0, 1'b0);
        send_item(OP_CHAR, ".");
        send_item(OP_CHAR, "?");
        send_item(OP_EOT, 8'hFF);

        for (seg = 0; seg < SEGMENTS; seg++) begin
            drain();
            configure(1'($urandom_range(1)), 1'($urandom_range(1)));
            case (seg / 2)
                0: begin
                    tx_idle_pct = 31;
                    rx_idle_pct = 69;
                end
                1: begin
                    tx_idle_pct = 69;
                    rx_idle_pct = 31;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            if (seg == 4) squeeze_go = 1'b1;
            goal = items_with_units + SEGMENT_ITEMS;
            send_message(seg % 2 == 0);
            while (items_with_units < goal) send_message($urandom_range(99) < 15);
        end
        drain();

        if (errors == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
